// ----- rtl/slnt_pkg.sv -----
// shared types, constants and codes for the sorted line number table
package slnt_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int BODY_WIDTH  = 32;

    localparam int KEY_W    = 31;
    localparam int IDX_W    = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int RDX_W    = (IDX_W > 9) ? IDX_W : 9;

    // gather tree: cells are reduced in groups, then the groups are reduced
    localparam int GROUP_SIZE  = 32;
    localparam int GROUP_COUNT = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_DEPTH   = GROUP_COUNT * GROUP_SIZE;
    localparam int GRP_W       = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [BODY_WIDTH-1:0] body_t;

    typedef enum logic [2:0] {
        MODE_STORE  = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_FIND   = 3'd2,
        MODE_READ   = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_OVW,
        CELL_DEL
    } cell_op_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        cell_op_t           op;
        key_t               key;
        body_t              body;
        logic [IDX_W-1:0]   pos;
        logic [RDX_W-1:0]   rd_index;
        logic [CNT_W-1:0]   count;
    } cell_cmd_t;

    // one selected entry out of the gather tree
    typedef struct packed {
        logic             any;
        logic [IDX_W-1:0] idx;
        key_t             key;
        body_t            body;
    } pick_t;

endpackage

// ----- rtl/slnt_item_if.sv -----
// request channel: one table operation per beat
interface slnt_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [30:0] line_number;
    logic [31:0] line_body;
    logic [8:0]  entry_index;

    modport source (output valid, mode, line_number, line_body, entry_index, input ready);
    modport sink   (input valid, mode, line_number, line_body, entry_index, output ready);
endinterface

// ----- rtl/slnt_result_if.sv -----
// response channel: one result per beat
interface slnt_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [8:0]  found_index;
    logic [30:0] entry_number;
    logic [31:0] entry_body;
    logic [9:0]  entry_total;

    modport source (output valid, status, found_index, entry_number, entry_body, entry_total,
                    input ready);
    modport sink   (input valid, status, found_index, entry_number, entry_body, entry_total,
                    output ready);
endinterface

// ----- rtl/slnt_cell.sv -----
// one table slot: holds an entry, compares it and shifts with its neighbors
module slnt_cell
    import slnt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_index,
    input  cell_cmd_t        cmd,
    input  key_t             prev_key,
    input  body_t            prev_body,
    input  key_t             next_key,
    input  body_t            next_body,
    output key_t             key,
    output body_t            body,
    output logic             ge,
    output logic             rd
);

    key_t  key_reg;
    key_t  key_next;
    body_t body_reg;
    body_t body_next;
    logic  ge_reg;
    logic  ge_next;
    logic  rd_reg;
    logic  rd_next;
    logic  slot_valid;

    assign slot_valid = CNT_W'(cell_index) < cmd.count;

    // compare flags and entry movement
    always_comb
    begin
        key_next  = key_reg;
        body_next = body_reg;
        ge_next   = ge_reg;
        rd_next   = rd_reg;
        case (cmd.op)
            CELL_CMP:
            begin
                // empty slots count as greater so the first one marks the end
                ge_next = !slot_valid || (key_reg >= cmd.key);
                rd_next = slot_valid && (RDX_W'(cell_index) == cmd.rd_index);
            end
            CELL_INS:
            begin
                if (cell_index == cmd.pos)
                begin
                    key_next  = cmd.key;
                    body_next = cmd.body;
                end
                else if (cell_index > cmd.pos)
                begin
                    key_next  = prev_key;
                    body_next = prev_body;
                end
            end
            CELL_OVW:
            begin
                if (cell_index == cmd.pos)
                begin
                    body_next = cmd.body;
                end
            end
            CELL_DEL:
            begin
                if (cell_index >= cmd.pos)
                begin
                    key_next  = next_key;
                    body_next = next_body;
                end
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        body_reg <= body_next;
    end

    // compare flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg <= 1'b0;
            rd_reg <= 1'b0;
        end
        else
        begin
            ge_reg <= ge_next;
            rd_reg <= rd_next;
        end
    end

    assign key  = key_reg;
    assign body = body_reg;
    assign ge   = ge_reg;
    assign rd   = rd_reg;

endmodule

// ----- rtl/slnt_group.sv -----
// registered gather of the selected entry within one group of cells
module slnt_group
    import slnt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [GRP_W-1:0]      group_id,
    input  logic [GROUP_SIZE-1:0] sel,
    input  key_t                  keys   [GROUP_SIZE],
    input  body_t                 bodies [GROUP_SIZE],
    output pick_t                 pick
);

    pick_t pick_reg;
    pick_t pick_next;

    // at most one select is set, so an or of masked fields picks it
    always_comb
    begin
        pick_next = '0;
        for (int j = 0; j < GROUP_SIZE; j++)
        begin
            if (sel[j])
            begin
                pick_next.any  = 1'b1;
                pick_next.idx  = pick_next.idx
                               | IDX_W'(int'(group_id) * GROUP_SIZE + j);
                pick_next.key  = pick_next.key  | keys[j];
                pick_next.body = pick_next.body | bodies[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_reg <= '0;
        end
        else
        begin
            pick_reg <= pick_next;
        end
    end

    assign pick = pick_reg;

endmodule

// ----- rtl/sorted_line_number_table_top.sv -----
// top level of the sorted line number table: cell row, gather tree and sequencer
//
// The table holds up to TABLE_DEPTH entries kept in ascending line number
// order, one entry per cell in a row of cells. An operation runs through the
// states compare, gather, pick and apply, and the result register is loaded
// at the end of apply. In the compare state every cell checks its key (and its
// position) against the request. The gather and pick states pass through the
// registered gather tree (groups of 32 cells, then across the groups). In the
// apply state the outcome is decided and the cells shift, overwrite or hold.
// The apply state waits while the previous result has not been taken. A new
// request is taken only in the idle state that follows the apply, so a new
// operation is not accepted until the previous one has been applied. Inserts
// and deletes move the whole tail of the row at once in the apply cycle. Clear
// only resets the entry count; no clearing pass runs after reset and the block
// is ready as soon as reset is released.
module sorted_line_number_table_top
    import slnt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    slnt_item_if.sink     item,
    slnt_result_if.source result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_GATHER,
        S_PICK,
        S_APPLY
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [2:0]         mode_reg;
    key_t               key_in_reg;
    body_t              body_in_reg;
    logic [RDX_W-1:0]   rdx_reg;
    pick_t              pick_reg;
    pick_t              pick_next;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [8:0]         out_index_reg;
    key_t               out_key_reg;
    body_t              out_body_reg;
    logic [9:0]         out_total_reg;

    logic               accept;
    logic               apply_fire;
    cell_cmd_t          cmd;
    cell_op_t           apply_op;
    status_t            apply_status;
    logic               apply_hit;
    logic               pick_in_range;
    logic               found;

    key_t               key_q  [TABLE_DEPTH];
    body_t              body_q [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] ge_q;
    logic [TABLE_DEPTH-1:0] rd_q;

    logic [PAD_DEPTH-1:0] sel_pad;
    key_t               key_pad  [PAD_DEPTH];
    body_t              body_pad [PAD_DEPTH];
    pick_t              grp_pick [GROUP_COUNT];
    logic [GROUP_COUNT-1:0] grp_any;

    assign accept     = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign apply_fire = (state_reg == S_APPLY) && (!out_valid_reg || result.ready);

    // outcome of the picked entry
    assign pick_in_range = CNT_W'(pick_reg.idx) < count_reg;
    assign found = pick_reg.any && pick_in_range && (pick_reg.key == key_in_reg);

    always_comb
    begin
        apply_op     = CELL_HOLD;
        apply_status = ST_OK;
        apply_hit    = 1'b0;
        count_next   = count_reg;
        case (mode_reg)
            MODE_STORE:
            begin
                if (found)
                begin
                    apply_op  = CELL_OVW;
                    apply_hit = 1'b1;
                end
                else if (count_reg < CNT_W'(TABLE_DEPTH))
                begin
                    apply_op   = CELL_INS;
                    apply_hit  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    apply_status = ST_FULL;
                end
            end
            MODE_DELETE:
            begin
                if (found)
                begin
                    apply_op   = CELL_DEL;
                    apply_hit  = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    apply_status = ST_MISSING;
                end
            end
            MODE_FIND:
            begin
                if (found)
                begin
                    apply_hit = 1'b1;
                end
                else
                begin
                    apply_status = ST_MISSING;
                end
            end
            MODE_READ:
            begin
                if (pick_reg.any)
                begin
                    apply_hit = 1'b1;
                end
                else
                begin
                    apply_status = ST_RANGE;
                end
            end
            MODE_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                apply_status = ST_OK;
            end
        endcase
    end

    // broadcast command to the row
    always_comb
    begin
        cmd.op       = CELL_HOLD;
        cmd.key      = key_in_reg;
        cmd.body     = body_in_reg;
        cmd.pos      = pick_reg.idx;
        cmd.rd_index = rdx_reg;
        cmd.count    = count_reg;
        if (state_reg == S_CMP)
        begin
            cmd.op = CELL_CMP;
        end
        else if (apply_fire)
        begin
            cmd.op = apply_op;
        end
    end

    // row of cells with neighbor links
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        key_t  prev_key;
        body_t prev_body;
        key_t  next_key;
        body_t next_body;

        if (i > 0)
        begin : g_prev
            assign prev_key  = key_q[i-1];
            assign prev_body = body_q[i-1];
        end
        else
        begin : g_first
            assign prev_key  = key_q[i];
            assign prev_body = body_q[i];
        end

        if (i < TABLE_DEPTH - 1)
        begin : g_next
            assign next_key  = key_q[i+1];
            assign next_body = body_q[i+1];
        end
        else
        begin : g_last
            assign next_key  = key_q[i];
            assign next_body = body_q[i];
        end

        slnt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(i)),
            .cmd        (cmd),
            .prev_key   (prev_key),
            .prev_body  (prev_body),
            .next_key   (next_key),
            .next_body  (next_body),
            .key        (key_q[i]),
            .body       (body_q[i]),
            .ge         (ge_q[i]),
            .rd         (rd_q[i])
        );
    end

    // select: position match on read, else the first cell at or above the key
    for (genvar i = 0; i < PAD_DEPTH; i++)
    begin : g_sel
        if (i == 0)
        begin : g_head
            assign sel_pad[i]  = (mode_reg == MODE_READ) ? rd_q[i] : ge_q[i];
            assign key_pad[i]  = key_q[i];
            assign body_pad[i] = body_q[i];
        end
        else if (i < TABLE_DEPTH)
        begin : g_body
            assign sel_pad[i]  = (mode_reg == MODE_READ) ? rd_q[i] : (ge_q[i] && !ge_q[i-1]);
            assign key_pad[i]  = key_q[i];
            assign body_pad[i] = body_q[i];
        end
        else
        begin : g_pad
            assign sel_pad[i]  = 1'b0;
            assign key_pad[i]  = '0;
            assign body_pad[i] = '0;
        end
    end

    // first level of the gather tree
    for (genvar g = 0; g < GROUP_COUNT; g++)
    begin : g_grp
        key_t  grp_keys   [GROUP_SIZE];
        body_t grp_bodies [GROUP_SIZE];

        for (genvar j = 0; j < GROUP_SIZE; j++)
        begin : g_lane
            assign grp_keys[j]   = key_pad[g*GROUP_SIZE + j];
            assign grp_bodies[j] = body_pad[g*GROUP_SIZE + j];
        end

        slnt_group u_group (
            .clk      (clk),
            .rst_n    (rst_n),
            .group_id (GRP_W'(g)),
            .sel      (sel_pad[g*GROUP_SIZE +: GROUP_SIZE]),
            .keys     (grp_keys),
            .bodies   (grp_bodies),
            .pick     (grp_pick[g])
        );

        assign grp_any[g] = grp_pick[g].any;
    end

    // second level of the gather tree
    always_comb
    begin
        pick_next = '0;
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            pick_next.any  = pick_next.any  | grp_pick[g].any;
            pick_next.idx  = pick_next.idx  | grp_pick[g].idx;
            pick_next.key  = pick_next.key  | grp_pick[g].key;
            pick_next.body = pick_next.body | grp_pick[g].body;
        end
    end

    // sequencing of one operation
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:    state_next = S_GATHER;
            S_GATHER: state_next = S_PICK;
            S_PICK:   state_next = S_APPLY;
            S_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // state, count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_total_reg  <= '0;
            out_index_reg  <= '0;
            out_key_reg    <= '0;
            out_body_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (apply_fire)
            begin
                count_reg      <= count_next;
                out_valid_reg  <= 1'b1;
                out_status_reg <= apply_status;
                out_total_reg  <= 10'(count_next);
                if (apply_hit)
                begin
                    out_index_reg <= 9'(pick_reg.idx);
                    if (mode_reg == MODE_STORE)
                    begin
                        out_key_reg  <= key_in_reg;
                        out_body_reg <= body_in_reg;
                    end
                    else
                    begin
                        out_key_reg  <= pick_reg.key;
                        out_body_reg <= pick_reg.body;
                    end
                end
                else
                begin
                    out_index_reg <= '0;
                    out_key_reg   <= '0;
                    out_body_reg  <= '0;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request fields and picked entry
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= item.mode;
            key_in_reg  <= item.line_number;
            body_in_reg <= BODY_WIDTH'(item.line_body);
            rdx_reg     <= RDX_W'(item.entry_index);
        end
        // group registers hold this operation's picks during the pick cycle
        if (state_reg == S_PICK)
        begin
            pick_reg <= pick_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.found_index  = out_index_reg;
    assign result.entry_number = out_key_reg;
    assign result.entry_body   = 32'(out_body_reg);
    assign result.entry_total  = out_total_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_CMP)
        else $error("accepted beat did not start a compare");

    a_one_group: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PICK |-> $onehot0(grp_any))
        else $error("more than one group selected");

    a_count_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(state_reg) == S_APPLY)
        else $error("entry count changed outside apply");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_FULL |-> count_reg == CNT_W'(TABLE_DEPTH))
        else $error("full status with free slots");
`endif

endmodule

// ----- bench/sorted_line_number_table_top_test.sv -----
// self-checking bench for the sorted line number table with its own table predictor
module sorted_line_number_table_top_test;
    import slnt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]       MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0]       MODE_SPARE_LAST  = 3'd7;
    localparam key_t             KEY_MAX          = '1;
    localparam body_t            BODY_MAX         = '1;
    localparam logic [IDX_W-1:0] INDEX_MAX        = '1;

    typedef struct packed {
        logic [2:0]       mode;
        key_t             number;
        body_t            body;
        logic [IDX_W-1:0] index;
    } table_req_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] idx;
        key_t             number;
        body_t            body;
        logic [CNT_W-1:0] total;
    } table_resp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    slnt_item_if   item ();
    slnt_result_if result ();

    sorted_line_number_table_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    // predicted table contents, in ascending key order
    key_t  table_keys   [TABLE_DEPTH];
    body_t table_bodies [TABLE_DEPTH];
    int    table_count = 0;

    table_resp_t expected_results [$];
    table_resp_t want;
    int          fault_count     = 0;
    bit          sender_steady   = 1'b0;
    bit          receiver_steady = 1'b0;
    int          rx_hold_cycles  = 0;

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // position of a key among the valid entries, -1 when absent
    function automatic int slot_of(key_t number);
        int i;
        for (i = 0; i < table_count; i++)
        begin
            if (table_keys[i] == number)
                return i;
        end
        return -1;
    endfunction

    function automatic table_resp_t entry_view(int pos);
        table_resp_t o;
        o        = '0;
        o.status = ST_OK;
        o.idx    = IDX_W'(pos);
        o.number = table_keys[pos];
        o.body   = table_bodies[pos];
        return o;
    endfunction

    // apply one operation to the predicted table and return its result
    function automatic table_resp_t predict_table_op(table_req_t r);
        table_resp_t o;
        int          hit;
        int          pos;
        int          i;
        o   = '0;
        hit = slot_of(r.number);
        case (r.mode)
            MODE_STORE:
            begin
                if (hit >= 0)
                begin
                    table_bodies[hit] = r.body;
                    o = entry_view(hit);
                end
                else if (table_count >= TABLE_DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    // shift larger keys up until the slot is found
                    pos = table_count;
                    while (pos > 0 && table_keys[pos-1] > r.number)
                    begin
                        table_keys[pos]   = table_keys[pos-1];
                        table_bodies[pos] = table_bodies[pos-1];
                        pos--;
                    end
                    table_keys[pos]   = r.number;
                    table_bodies[pos] = r.body;
                    table_count++;
                    o = entry_view(pos);
                end
            end
            MODE_DELETE:
            begin
                if (hit < 0)
                    o.status = ST_MISSING;
                else
                begin
                    o = entry_view(hit);
                    for (i = hit; i < table_count - 1; i++)
                    begin
                        table_keys[i]   = table_keys[i+1];
                        table_bodies[i] = table_bodies[i+1];
                    end
                    table_count--;
                end
            end
            MODE_FIND:
            begin
                if (hit < 0)
                    o.status = ST_MISSING;
                else
                    o = entry_view(hit);
            end
            MODE_READ:
            begin
                if (int'(r.index) >= table_count)
                    o.status = ST_RANGE;
                else
                    o = entry_view(int'(r.index));
            end
            MODE_CLEAR:
                table_count = 0;
            default:
                o.status = ST_OK;
        endcase
        o.total = CNT_W'(table_count);
        return o;
    endfunction

    // offer one beat, predict its result once it is taken
    task automatic send_op(input logic [2:0] op, input key_t number, input body_t body,
                           input logic [IDX_W-1:0] index);
        int         gap;
        table_req_t req;
        gap = sender_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid       <= 1'b1;
        item.mode        <= op;
        item.line_number <= number;
        item.line_body   <= body;
        item.entry_index <= index;
        do
            @(posedge clk);
        while (!item.ready);
        req.mode   = op;
        req.number = number;
        req.body   = body;
        req.index  = index;
        expected_results.push_back(predict_table_op(req));
    endtask

    // mostly keys already in the table, then a dense low range, then anything
    function automatic key_t pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50 && table_count > 0)
            return table_keys[$urandom_range(0, table_count - 1)];
        if (r < 80)
            return key_t'($urandom_range(0, 63));
        return key_t'($urandom);
    endfunction

    function automatic key_t fresh_key();
        key_t k;
        do
            k = key_t'($urandom);
        while (slot_of(k) >= 0);
        return k;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned top;
        top = (table_count + 3 > int'(INDEX_MAX)) ? INDEX_MAX : table_count + 3;
        if ($urandom_range(0, 3) == 0)
            return IDX_W'($urandom_range(0, INDEX_MAX));
        return IDX_W'($urandom_range(0, top));
    endfunction

    task automatic send_random_op();
        int unsigned pick;
        logic [2:0]  op;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = MODE_STORE;
        else if (pick < 60)
            op = MODE_DELETE;
        else if (pick < 75)
            op = MODE_FIND;
        else if (pick < 93)
            op = MODE_READ;
        else if (pick < 96)
            op = MODE_CLEAR;
        else
            op = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        send_op(op, pick_key(), body_t'($urandom), pick_index());
    endtask

    // empty table, extreme keys and bodies, every mode and every miss
    task automatic test_directed();
        logic [2:0] m;
        send_op(MODE_READ, '0, '0, '0);
        send_op(MODE_FIND, 31'd5, '0, '0);
        send_op(MODE_DELETE, 31'd5, '0, '0);
        send_op(MODE_STORE, KEY_MAX, BODY_MAX, INDEX_MAX);
        send_op(MODE_STORE, '0, '0, '0);
        send_op(MODE_STORE, 31'd1000, 32'h1234_5678, '0);
        send_op(MODE_STORE, 31'd1000, 32'hcafe_f00d, '0);
        send_op(MODE_FIND, '0, BODY_MAX, '0);
        send_op(MODE_FIND, KEY_MAX, '0, '0);
        send_op(MODE_READ, '0, '0, 9'd0);
        send_op(MODE_READ, '0, '0, 9'd1);
        send_op(MODE_READ, '0, '0, 9'd2);
        send_op(MODE_READ, '0, '0, 9'd3);
        send_op(MODE_READ, '0, '0, INDEX_MAX);
        send_op(MODE_DELETE, 31'd1000, '0, '0);
        send_op(MODE_DELETE, '0, '0, '0);
        send_op(MODE_DELETE, KEY_MAX, '0, '0);
        for (m = MODE_SPARE_FIRST; m != 3'(MODE_SPARE_LAST + 1); m++)
            send_op(m, 31'd7, BODY_MAX, INDEX_MAX);
        send_op(MODE_STORE, 31'd7, 32'h0bad_beef, '0);
        send_op(MODE_CLEAR, '0, '0, '0);
        send_op(MODE_READ, '0, '0, '0);
        send_op(MODE_FIND, 31'd7, '0, '0);
    endtask

    // fill to capacity in random key order, then work at the full boundary
    task automatic test_full_table();
        key_t k;
        while (table_count < TABLE_DEPTH)
            send_op(MODE_STORE, key_t'($urandom), body_t'($urandom), pick_index());
        send_op(MODE_STORE, fresh_key(), body_t'($urandom), '0);
        send_op(MODE_STORE, table_keys[100], body_t'($urandom), '0);
        send_op(MODE_FIND, table_keys[TABLE_DEPTH-1], '0, '0);
        send_op(MODE_READ, '0, '0, INDEX_MAX);
        send_op(MODE_READ, '0, '0, '0);
        send_op(MODE_DELETE, table_keys[256], '0, '0);
        send_op(MODE_STORE, fresh_key(), body_t'($urandom), '0);
        send_op(MODE_STORE, fresh_key(), body_t'($urandom), '0);
        k = table_keys[TABLE_DEPTH-1];
        send_op(MODE_DELETE, k, '0, '0);
        send_op(MODE_READ, '0, '0, INDEX_MAX);
        send_op(MODE_CLEAR, '0, '0, '0);
        send_op(MODE_READ, '0, '0, '0);
    endtask

    // random mix, with and without gaps on either side
    task automatic test_random_mix();
        int seg;
        for (seg = 0; seg < 4; seg++)
        begin
            sender_steady   = (seg == 1);
            receiver_steady = (seg == 2);
            repeat (20) send_random_op();
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // result side holds off long while beats keep coming
    task automatic test_backpressure();
        sender_steady  = 1'b1;
        rx_hold_cycles = 80;
        repeat (30) send_random_op();
        sender_steady  = 1'b0;
    endtask

    // result side ready pattern
    initial
    begin
        int stall;
        result.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                result.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            stall = receiver_steady ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result.valid);
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (exp_val !== got_val)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, got_val);
            fault_count++;
        end
    endtask

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: result beat with nothing expected, status %0d index %0d",
                         $time, result.status, result.found_index);
                fault_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(result.status));
                check_field("found_index", 32'(want.idx), 32'(result.found_index));
                check_field("entry_number", 32'(want.number), 32'(result.entry_number));
                check_field("entry_body", 32'(want.body), 32'(result.entry_body));
                check_field("entry_total", 32'(want.total), 32'(result.entry_total));
            end
        end
    end

    // test sequence
    initial
    begin
        item.valid       <= 1'b0;
        item.mode        <= MODE_STORE;
        item.line_number <= '0;
        item.line_body   <= '0;
        item.entry_index <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_table();
        test_random_mix();
        test_backpressure();
        item.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fault_count == 0)
            $display("sorted_line_number_table_top test passed");
        else
            $display("sorted_line_number_table_top test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("sorted_line_number_table_top test failed");
        $finish;
    end

endmodule
